[hw/rtl/rmq_pkg.sv]
// Shared types and constants for the rotation-matrix-to-quaternion core.
// Depends on nothing; the top level of the block refers to it by scoped names.
package rmq_pkg;

  // Default number of fraction bits of the Q2.30 format.
  localparam int FracBitsDefault = 30;

  // Width of one matrix entry and of one quaternion component at the ports.
  localparam int EntryW = 32;

  // Magnitude of a sum or difference of two entries; a sum can reach 2^32.
  localparam int NumMagW = 33;

  // Magnitude of a quaternion component before normalization; it can reach 2^31.
  localparam int CompMagW = 32;

  // Quotient bits of the first division; the quotient is at most 2^31.
  localparam int Quot1W = 32;

  // Number of non-leading components that are divided by four times the lead.
  localparam int NumLanes = 3;

  // Number of quaternion components.
  localparam int NumComps = 4;

  // Which component leads the extraction.
  typedef enum logic [1:0] {
    LeadW = 2'd0,
    LeadX = 2'd1,
    LeadY = 2'd2,
    LeadZ = 2'd3
  } lead_e;

  // One input transaction: the nine matrix entries.
  typedef struct packed {
    logic signed [EntryW-1:0] m00;
    logic signed [EntryW-1:0] m01;
    logic signed [EntryW-1:0] m02;
    logic signed [EntryW-1:0] m10;
    logic signed [EntryW-1:0] m11;
    logic signed [EntryW-1:0] m12;
    logic signed [EntryW-1:0] m20;
    logic signed [EntryW-1:0] m21;
    logic signed [EntryW-1:0] m22;
  } mat_item_t;

  // One output transaction: the unit quaternion and the invalid flag.
  typedef struct packed {
    logic signed [EntryW-1:0] quat_w;
    logic signed [EntryW-1:0] quat_x;
    logic signed [EntryW-1:0] quat_y;
    logic signed [EntryW-1:0] quat_z;
    logic                     invalid;
  } quat_item_t;

endpackage

[hw/rtl/rmq_stream_if.sv]
// Valid/ready stream interface used for both channels of the core.
// The payload type is a parameter; the block uses the structs of rmq_pkg.
interface rmq_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[hw/rtl/rmq_sqrt_pipe.sv]
// Pipelined integer square root: one root bit per register stage.
// Standalone; the top level hands it widths and a sideband that rides along.
module rmq_sqrt_pipe #(
  parameter int RAD_W  = 62,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RAD_W-1:0]    rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [RAD_W/2-1:0]  root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int RootW = RAD_W / 2;
  localparam int RemW  = RootW + 2;

  logic                vld_q  [RootW];
  logic [RemW-1:0]     rem_q  [RootW];
  logic [RootW-1:0]    root_q [RootW];
  logic [RAD_W-1:0]    rad_q  [RootW];
  logic [SIDE_W-1:0]   side_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic              vld_in;
    logic [RemW-1:0]   rem_in;
    logic [RootW-1:0]  root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [RemW-1:0]   rem_sh;
    logic [RemW-1:0]   trial;
    logic              take;
    logic [RemW-1:0]   rem_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {rem_in[RemW-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);
    assign rem_d  = take ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= {root_in[RootW-2:0], take};
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

[hw/rtl/rmq_div_pipe.sv]
// Pipelined restoring divider: one quotient bit per stage, several lanes
// sharing one divisor. Standalone; widths and sideband come from the top level.
module rmq_div_pipe #(
  parameter int DVD_W  = 62,
  parameter int DEN_W  = 33,
  parameter int QUOT_W = 31,
  parameter int LANES  = 3,
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [DEN_W-1:0]             den_i,
  input  logic [LANES-1:0][DVD_W-1:0]  dvd_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         valid_o,
  output logic [LANES-1:0][QUOT_W-1:0] quot_o,
  output logic [SIDE_W-1:0]            side_o
);

  // The quotient fits in QUOT_W bits, so the top of the dividend is below
  // the divisor and serves as the starting remainder.
  logic                          vld_q  [QUOT_W];
  logic [DEN_W-1:0]              den_q  [QUOT_W];
  logic [LANES-1:0][DEN_W-1:0]   rem_q  [QUOT_W];
  logic [LANES-1:0][QUOT_W-1:0]  ql_q   [QUOT_W];
  logic [SIDE_W-1:0]             side_q [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic                         vld_in;
    logic [DEN_W-1:0]             den_in;
    logic [LANES-1:0][DEN_W-1:0]  rem_in;
    logic [LANES-1:0][QUOT_W-1:0] ql_in;
    logic [SIDE_W-1:0]            side_in;
    logic [LANES-1:0][DEN_W-1:0]  rem_d;
    logic [LANES-1:0][QUOT_W-1:0] ql_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign rem_in[l] = DEN_W'(dvd_i[l][DVD_W-1:QUOT_W]);
        assign ql_in[l]  = dvd_i[l][QUOT_W-1:0];
      end
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign den_in  = den_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign ql_in   = ql_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in the next dividend bit and subtract the divisor where it fits.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] rs;
      logic [DEN_W:0] diff;
      logic           take;
      assign rs        = {rem_in[l], ql_in[l][QUOT_W-1]};
      assign diff      = rs - {1'b0, den_in};
      assign take      = (rs >= {1'b0, den_in});
      assign rem_d[l]  = take ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
      assign ql_d[l]   = {ql_in[l][QUOT_W-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        rem_q[k]  <= rem_d;
        ql_q[k]   <= ql_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUOT_W-1];
  assign quot_o  = ql_q[QUOT_W-1];
  assign side_o  = side_q[QUOT_W-1];

endmodule

[hw/rtl/rotation_matrix_to_quaternion_core.sv]
// Rotation matrix to unit quaternion, fixed point, fully pipelined: a new matrix
// is taken in every cycle and one quaternion leaves per cycle while the output is
// not stalled. The path runs through two bit-per-stage square roots and two
// bit-per-stage divider pipelines; the whole pipeline advances together and holds
// while a finished transaction waits at the output register.
// Depends on rmq_pkg, rmq_stream_if, rmq_sqrt_pipe and rmq_div_pipe.
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = rmq_pkg::FracBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rmq_stream_if.sink   mat_i,
  rmq_stream_if.source quat_o
);

  localparam int EntryW  = rmq_pkg::EntryW;
  localparam int NumW    = rmq_pkg::NumMagW;
  localparam int CompW   = rmq_pkg::CompMagW;
  localparam int Q1W     = rmq_pkg::Quot1W;
  localparam int Lanes   = rmq_pkg::NumLanes;
  localparam int Comps   = rmq_pkg::NumComps;
  localparam int SumW    = EntryW + 2;
  localparam int Rad1W   = 2 * ((FRAC_BITS + 33) / 2);
  localparam int Root1W  = Rad1W / 2;
  localparam int Den1W   = Root1W + 2;
  localparam int Dvd1W   = NumW + FRAC_BITS;
  localparam int SqW     = 2 * CompW;
  // The sum of the four squares stays below 2^64: large lanes need a small lead.
  localparam int Rad2W   = 2 * CompW;
  localparam int Root2W  = Rad2W / 2;
  localparam int Q2W     = FRAC_BITS + 1;
  localparam int Dvd2W   = CompW + FRAC_BITS;

  typedef struct packed {
    logic                          inv;
    rmq_pkg::lead_e                sel;
    logic [Lanes-1:0][NumW-1:0]    mag;
    logic [Lanes-1:0]              neg;
  } sqrt1_side_t;

  typedef struct packed {
    logic                          inv;
    rmq_pkg::lead_e                sel;
    logic [Lanes-1:0]              neg;
    logic [Root1W-1:0]             lead;
  } div1_side_t;

  typedef struct packed {
    logic                          inv;
    logic [Comps-1:0][CompW-1:0]   mag;
    logic [Comps-1:0]              neg;
  } sqrt2_side_t;

  typedef struct packed {
    logic                          inv;
    logic [Comps-1:0]              neg;
  } div2_side_t;

  // Global advance: the pipeline moves unless a result waits at the output.
  logic en;
  logic out_vld_q;
  rmq_pkg::quat_item_t out_q;

  assign en          = !out_vld_q || quat_o.ready;
  assign mat_i.ready = en;

  // ---------------------------------------------------------------------------
  // Case selection: the four sums, the leading case and the numerators.
  // ---------------------------------------------------------------------------
  logic signed [SumW-1:0] e00, e11, e22, t_sum, dx_sum, dy_sum, dz_sum, s_sel;
  logic signed [NumW:0]   d21_12, d02_20, d10_01, s10_01, s20_02, s21_12;
  logic signed [NumW:0]   num [Lanes];
  logic [SumW-1:0]        arg;
  logic                   inv_d;
  rmq_pkg::lead_e         sel_d;
  logic [Rad1W-1:0]       rad_d;
  sqrt1_side_t            s0_side_d;

  logic                   s0_vld_q;
  logic [Rad1W-1:0]       s0_rad_q;
  sqrt1_side_t            s0_side_q;

  always_comb begin
    e00    = SumW'($signed(mat_i.payload.m00));
    e11    = SumW'($signed(mat_i.payload.m11));
    e22    = SumW'($signed(mat_i.payload.m22));
    t_sum  = e00 + e11 + e22;
    dx_sum = e00 - e11 - e22;
    dy_sum = e11 - e00 - e22;
    dz_sum = e22 - e00 - e11;

    d21_12 = (NumW+1)'($signed(mat_i.payload.m21)) - (NumW+1)'($signed(mat_i.payload.m12));
    d02_20 = (NumW+1)'($signed(mat_i.payload.m02)) - (NumW+1)'($signed(mat_i.payload.m20));
    d10_01 = (NumW+1)'($signed(mat_i.payload.m10)) - (NumW+1)'($signed(mat_i.payload.m01));
    s10_01 = (NumW+1)'($signed(mat_i.payload.m10)) + (NumW+1)'($signed(mat_i.payload.m01));
    s20_02 = (NumW+1)'($signed(mat_i.payload.m20)) + (NumW+1)'($signed(mat_i.payload.m02));
    s21_12 = (NumW+1)'($signed(mat_i.payload.m21)) + (NumW+1)'($signed(mat_i.payload.m12));

    inv_d = 1'b0;
    if (t_sum > 0) begin
      sel_d = rmq_pkg::LeadW;
      s_sel = t_sum;
    end else if (dx_sum > 0) begin
      sel_d = rmq_pkg::LeadX;
      s_sel = dx_sum;
    end else if (dy_sum > 0) begin
      sel_d = rmq_pkg::LeadY;
      s_sel = dy_sum;
    end else if (dz_sum > 0) begin
      sel_d = rmq_pkg::LeadZ;
      s_sel = dz_sum;
    end else begin
      sel_d = rmq_pkg::LeadW;
      s_sel = '0;
      inv_d = 1'b1;
    end

    // Lanes hold the non-leading components in component order.
    unique case (sel_d)
      rmq_pkg::LeadW: begin
        num[0] = d21_12;
        num[1] = d02_20;
        num[2] = d10_01;
      end
      rmq_pkg::LeadX: begin
        num[0] = d21_12;
        num[1] = s10_01;
        num[2] = s20_02;
      end
      rmq_pkg::LeadY: begin
        num[0] = d02_20;
        num[1] = s10_01;
        num[2] = s21_12;
      end
      default: begin
        num[0] = d10_01;
        num[1] = s20_02;
        num[2] = s21_12;
      end
    endcase

    // Radicand (ONE + s) * 2^(FRAC_BITS-2) gives half the root of 1 + s.
    arg   = SumW'(s_sel) + (SumW'(1) << FRAC_BITS);
    rad_d = Rad1W'(arg) << (FRAC_BITS - 2);

    s0_side_d.inv = inv_d;
    s0_side_d.sel = sel_d;
    for (int l = 0; l < Lanes; l++) begin
      s0_side_d.neg[l] = num[l][NumW];
      s0_side_d.mag[l] = num[l][NumW] ? NumW'(-num[l]) : num[l][NumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= mat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_rad_q  <= rad_d;
      s0_side_q <= s0_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Leading component: square root of the radicand.
  // ---------------------------------------------------------------------------
  logic                 r1_vld;
  logic [Root1W-1:0]    r1_root;
  sqrt1_side_t          r1_side;

  rmq_sqrt_pipe #(
    .RAD_W  (Rad1W),
    .SIDE_W ($bits(sqrt1_side_t))
  ) u_sqrt_lead (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_vld_q),
    .rad_i   (s0_rad_q),
    .side_i  (s0_side_q),
    .valid_o (r1_vld),
    .root_o  (r1_root),
    .side_o  (r1_side)
  );

  // ---------------------------------------------------------------------------
  // Other three components: numerator * 2^FRAC_BITS / (4 * lead).
  // ---------------------------------------------------------------------------
  logic [Lanes-1:0][Dvd1W-1:0] dv1_dvd;
  div1_side_t                  dv1_side_in;
  logic                        dv1_vld;
  logic [Lanes-1:0][Q1W-1:0]   dv1_quot;
  div1_side_t                  dv1_side;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      dv1_dvd[l] = {r1_side.mag[l], {FRAC_BITS{1'b0}}};
    end
    dv1_side_in.inv  = r1_side.inv;
    dv1_side_in.sel  = r1_side.sel;
    dv1_side_in.neg  = r1_side.neg;
    dv1_side_in.lead = r1_root;
  end

  rmq_div_pipe #(
    .DVD_W  (Dvd1W),
    .DEN_W  (Den1W),
    .QUOT_W (Q1W),
    .LANES  (Lanes),
    .SIDE_W ($bits(div1_side_t))
  ) u_div_lead (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r1_vld),
    .den_i   ({r1_root, 2'b00}),
    .dvd_i   (dv1_dvd),
    .side_i  (dv1_side_in),
    .valid_o (dv1_vld),
    .quot_o  (dv1_quot),
    .side_o  (dv1_side)
  );

  // ---------------------------------------------------------------------------
  // Assemble the four components and flip the sign when w is negative.
  // ---------------------------------------------------------------------------
  logic [Comps-1:0][CompW-1:0] cm_d;
  logic [Comps-1:0]            cn_d;
  logic [CompW-1:0]            lead_mag;
  logic [Lanes-1:0]            lane_neg;
  logic                        w_neg;

  logic                        as_vld_q;
  logic                        as_inv_q;
  logic [Comps-1:0][CompW-1:0] as_mag_q;
  logic [Comps-1:0]            as_neg_q;

  always_comb begin
    lead_mag = CompW'(dv1_side.lead);
    for (int l = 0; l < Lanes; l++) begin
      lane_neg[l] = dv1_side.neg[l] && (dv1_quot[l] != '0);
    end
    unique case (dv1_side.sel)
      rmq_pkg::LeadW: begin
        cm_d = {dv1_quot[2], dv1_quot[1], dv1_quot[0], lead_mag};
        cn_d = {lane_neg[2], lane_neg[1], lane_neg[0], 1'b0};
      end
      rmq_pkg::LeadX: begin
        cm_d = {dv1_quot[2], dv1_quot[1], lead_mag, dv1_quot[0]};
        cn_d = {lane_neg[2], lane_neg[1], 1'b0, lane_neg[0]};
      end
      rmq_pkg::LeadY: begin
        cm_d = {dv1_quot[2], lead_mag, dv1_quot[1], dv1_quot[0]};
        cn_d = {lane_neg[2], 1'b0, lane_neg[1], lane_neg[0]};
      end
      default: begin
        cm_d = {lead_mag, dv1_quot[2], dv1_quot[1], dv1_quot[0]};
        cn_d = {1'b0, lane_neg[2], lane_neg[1], lane_neg[0]};
      end
    endcase
    w_neg = cn_d[0];
    if (w_neg) begin
      for (int i = 0; i < Comps; i++) begin
        cn_d[i] = (cm_d[i] != '0) && !cn_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      as_vld_q <= 1'b0;
    end else if (en) begin
      as_vld_q <= dv1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      as_inv_q <= dv1_side.inv;
      as_mag_q <= cm_d;
      as_neg_q <= cn_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sum of squares: one multiplier per component, then a two-level adder tree.
  // ---------------------------------------------------------------------------
  logic                        sq_vld_q, p1_vld_q, n2_vld_q;
  logic [Comps-1:0][SqW-1:0]   sq_q;
  logic [SqW:0]                p1_lo_q, p1_hi_q;
  logic [Rad2W-1:0]            n2_q;
  sqrt2_side_t                 sq_side_q, p1_side_q, n2_side_q;
  sqrt2_side_t                 as_side;

  always_comb begin
    as_side.inv = as_inv_q;
    as_side.mag = as_mag_q;
    as_side.neg = as_neg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      n2_vld_q <= 1'b0;
    end else if (en) begin
      sq_vld_q <= as_vld_q;
      p1_vld_q <= sq_vld_q;
      n2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < Comps; i++) begin
        sq_q[i] <= SqW'(as_mag_q[i]) * SqW'(as_mag_q[i]);
      end
      sq_side_q <= as_side;
      p1_lo_q   <= (SqW+1)'(sq_q[0]) + (SqW+1)'(sq_q[1]);
      p1_hi_q   <= (SqW+1)'(sq_q[2]) + (SqW+1)'(sq_q[3]);
      p1_side_q <= sq_side_q;
      n2_q      <= Rad2W'(p1_lo_q) + Rad2W'(p1_hi_q);
      n2_side_q <= p1_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Norm: square root of the sum of squares.
  // ---------------------------------------------------------------------------
  logic                 r2_vld;
  logic [Root2W-1:0]    r2_root;
  sqrt2_side_t          r2_side;

  rmq_sqrt_pipe #(
    .RAD_W  (Rad2W),
    .SIDE_W ($bits(sqrt2_side_t))
  ) u_sqrt_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n2_vld_q),
    .rad_i   (n2_q),
    .side_i  (n2_side_q),
    .valid_o (r2_vld),
    .root_o  (r2_root),
    .side_o  (r2_side)
  );

  // ---------------------------------------------------------------------------
  // Normalize: component * 2^FRAC_BITS / norm, never above one in magnitude.
  // ---------------------------------------------------------------------------
  logic [Comps-1:0][Dvd2W-1:0] dv2_dvd;
  div2_side_t                  dv2_side_in;
  logic                        dv2_vld;
  logic [Comps-1:0][Q2W-1:0]   dv2_quot;
  div2_side_t                  dv2_side;

  always_comb begin
    for (int i = 0; i < Comps; i++) begin
      dv2_dvd[i] = {r2_side.mag[i], {FRAC_BITS{1'b0}}};
    end
    dv2_side_in.inv = r2_side.inv;
    dv2_side_in.neg = r2_side.neg;
  end

  rmq_div_pipe #(
    .DVD_W  (Dvd2W),
    .DEN_W  (Root2W),
    .QUOT_W (Q2W),
    .LANES  (Comps),
    .SIDE_W ($bits(div2_side_t))
  ) u_div_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r2_vld),
    .den_i   (r2_root),
    .dvd_i   (dv2_dvd),
    .side_i  (dv2_side_in),
    .valid_o (dv2_vld),
    .quot_o  (dv2_quot),
    .side_o  (dv2_side)
  );

  // ---------------------------------------------------------------------------
  // Output register: restore signs, zero the result of an invalid matrix.
  // ---------------------------------------------------------------------------
  logic signed [EntryW-1:0] comp_d [Comps];
  rmq_pkg::quat_item_t      out_d;

  always_comb begin
    for (int i = 0; i < Comps; i++) begin
      comp_d[i] = dv2_side.neg[i] ? -$signed(EntryW'(dv2_quot[i]))
                                  : $signed(EntryW'(dv2_quot[i]));
      if (dv2_side.inv) begin
        comp_d[i] = '0;
      end
    end
    out_d.quat_w  = comp_d[0];
    out_d.quat_x  = comp_d[1];
    out_d.quat_y  = comp_d[2];
    out_d.quat_z  = comp_d[3];
    out_d.invalid = dv2_side.inv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign quat_o.valid   = out_vld_q;
  assign quat_o.payload = out_q;

endmodule
